[sv/status_led_mode_sequencer_assert.svh]
// Assertion macros for the status LED sequencer checker
`ifndef STATUS_LED_MODE_SEQUENCER_ASSERT_SVH
`define STATUS_LED_MODE_SEQUENCER_ASSERT_SVH

// consequent checked in the cycle after the antecedent, skipped in reset
`define SLED_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sled assertion failed");

// consequent checked in the same cycle, skipped in reset
`define SLED_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sled assertion failed");

// consequent checked in the cycle after the antecedent, active through reset
`define SLED_ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("sled assertion failed");

`endif

[sv/sled_pkg.sv]
// Types and constants of the status LED mode sequencer
package sled_pkg;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAUGE_FULL    = 3'd0,
        CFG_RADIO_ON      = 3'd1,
        CFG_RADIO_PERIOD  = 3'd2,
        CFG_CHARGE_ON     = 3'd3,
        CFG_CHARGE_PERIOD = 3'd4,
        CFG_MISS_ON       = 3'd5,
        CFG_MISS_PERIOD   = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_LOW     = 2'd0,
        MODE_MISSING = 2'd1,
        MODE_NORMAL  = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        COLOR_OFF    = 3'd0,
        COLOR_RED    = 3'd1,
        COLOR_BLUE   = 3'd2,
        COLOR_CYAN   = 3'd3,
        COLOR_ORANGE = 3'd4,
        COLOR_GREEN  = 3'd5,
        COLOR_GAUGE  = 3'd6
    } t_color;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BRIGHT_UP,
        PH_BLANK,
        PH_BRIGHT_LOW,
        PH_LOW_RED,
        PH_NORM,
        PH_MISS
    } t_phase;

    localparam logic [1:0] CHG_CHARGING = 2'd1;
    localparam logic [1:0] CHG_FAULT    = 2'd3;
    localparam logic [1:0] RADIO_WAIT   = 2'd1;
    localparam logic [1:0] RADIO_LINKED = 2'd2;
    localparam logic [1:0] HOST_OPER    = 2'd1;
    localparam logic [1:0] HOST_CTRL    = 2'd2;

    localparam logic [7:0] BRIGHT_NORMAL = 8'd24;
    localparam logic [7:0] BRIGHT_LOW    = 8'd10;

    typedef struct packed {
        logic       main_low;
        logic [5:0] drive_nonzero;
        logic       motor_pack_present;
        logic [1:0] charger_state;
        logic [6:0] main_level;
        logic [6:0] motor_level;
        logic [1:0] radio_state;
        logic [1:0] host_state;
    } t_tick;

    typedef struct packed {
        logic       target;
        logic [3:0] led_number;
        t_color     color_code;
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] brightness;
        logic       last_of_tick;
    } t_cmd;

    typedef struct packed {
        logic        bright_up;
        logic        blank;
        t_mode       mode;
        t_color      led0;
        t_color      led1;
        t_color      led2;
        t_color      led3;
        logic [14:0] main_gnum;
        logic [13:0] main_rnum;
        logic [14:0] motor_gnum;
        logic [13:0] motor_rnum;
    } t_plan;

endpackage

[sv/sled_stream_if.sv]
// Valid/ready stream channel with a typed payload
interface sled_stream_if #(
    parameter type T_DATA = logic
) ();
    logic  valid;
    logic  ready;
    T_DATA data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/sled_plan.sv]
// Input register, mode decision, blink counters and gauge products
module sled_plan #(
    parameter int MOTOR_TOTAL = 6
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sled_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [7:0]                       i_cfg_data,
    sled_stream_if.sink                      i_tick,
    output logic                             o_plan_valid,
    output sled_pkg::t_plan                  o_plan,
    input  logic                             i_plan_ready
);
    import sled_pkg::*;

    typedef struct packed {
        logic       lit;
        logic [7:0] cnt;
    } t_blink;

    function automatic t_blink blink(input logic [7:0] cnt, input logic [7:0] on,
                                     input logic [7:0] period);
        t_blink b;
        if (cnt < on) begin
            b.lit = 1'b1;
            b.cnt = cnt + 8'd1;
        end else if (cnt < period) begin
            b.lit = 1'b0;
            b.cnt = cnt + 8'd1;
        end else begin
            b.lit = 1'b0;
            b.cnt = 8'd0;
        end
        return b;
    endfunction

    // (clamp(p,10,90) - 10) * f + 40
    function automatic logic [14:0] green_num(input logic [6:0] p, input logic [7:0] f);
        logic [6:0] g;
        if (p < 7'd10) begin
            g = 7'd10;
        end else if (p > 7'd90) begin
            g = 7'd90;
        end else begin
            g = p;
        end
        return 15'(g - 7'd10) * 15'(f) + 15'd40;
    endfunction

    // (90 - clamp(p,50,90)) * f + 20
    function automatic logic [13:0] red_num(input logic [6:0] p, input logic [7:0] f);
        logic [6:0] r;
        if (p < 7'd50) begin
            r = 7'd50;
        end else if (p > 7'd90) begin
            r = 7'd90;
        end else begin
            r = p;
        end
        return 14'(7'd90 - r) * 14'(f) + 14'd20;
    endfunction

    logic [7:0] r_gauge_full, r_radio_on, r_radio_period;
    logic [7:0] r_charge_on, r_charge_period, r_miss_on, r_miss_period;

    logic       r_in_valid;
    t_tick      r_in;
    t_mode      r_prev_mode, n_prev_mode;
    logic [7:0] r_shared_cnt, n_shared_cnt;
    logic [7:0] r_charge_cnt, n_charge_cnt;

    logic [5:0] drive_mask;
    logic       drive_any;
    logic       change;
    logic [7:0] shared0, charge0;
    t_blink     bl_charge, bl_radio, bl_miss;
    logic       take;
    t_plan      plan;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            drive_mask[i] = (i < MOTOR_TOTAL);
        end
    end

    assign take         = r_in_valid && i_plan_ready;
    assign i_tick.ready = !r_in_valid || i_plan_ready;
    assign o_plan_valid = r_in_valid;
    assign o_plan       = plan;
    assign drive_any    = |(r_in.drive_nonzero & drive_mask);

    always_comb begin
        plan = '0;
        if (r_in.main_low) begin
            plan.mode = MODE_LOW;
        end else if (drive_any && !r_in.motor_pack_present) begin
            plan.mode = MODE_MISSING;
        end else if (r_prev_mode == MODE_MISSING && r_shared_cnt != 8'd0) begin
            plan.mode = MODE_MISSING;
        end else begin
            plan.mode = MODE_NORMAL;
        end

        change         = plan.mode != r_prev_mode;
        plan.blank     = change;
        plan.bright_up = change && r_prev_mode == MODE_LOW;
        shared0 = (change && plan.mode != MODE_LOW) ? 8'd0 : r_shared_cnt;
        charge0 = (change && plan.mode == MODE_NORMAL) ? 8'd0 : r_charge_cnt;

        bl_charge = blink(charge0, r_charge_on, r_charge_period);
        bl_radio  = blink(shared0, r_radio_on, r_radio_period);
        bl_miss   = blink(shared0, r_miss_on, r_miss_period);

        n_prev_mode  = plan.mode;
        n_shared_cnt = shared0;
        n_charge_cnt = charge0;
        plan.led0    = COLOR_GAUGE;
        plan.led1    = r_in.motor_pack_present ? COLOR_GAUGE : COLOR_OFF;
        plan.led2    = COLOR_OFF;
        plan.led3    = COLOR_RED;

        unique case (plan.mode)
            MODE_NORMAL: begin
                if (r_in.charger_state == CHG_CHARGING || r_in.charger_state == CHG_FAULT) begin
                    n_charge_cnt = bl_charge.cnt;
                    if (bl_charge.lit) begin
                        plan.led0 = (r_in.charger_state == CHG_CHARGING) ? COLOR_BLUE
                                                                         : COLOR_RED;
                    end
                end
                if (r_in.radio_state == RADIO_WAIT) begin
                    n_shared_cnt = bl_radio.cnt;
                    plan.led2    = bl_radio.lit ? COLOR_CYAN : COLOR_OFF;
                end else begin
                    n_shared_cnt = 8'd0;
                    plan.led2    = (r_in.radio_state == RADIO_LINKED) ? COLOR_CYAN : COLOR_OFF;
                end
                if (r_in.host_state == HOST_OPER) begin
                    plan.led3 = COLOR_ORANGE;
                end else if (r_in.host_state == HOST_CTRL) begin
                    plan.led3 = COLOR_GREEN;
                end
            end
            MODE_MISSING: begin
                n_shared_cnt = bl_miss.cnt;
                plan.led1    = bl_miss.lit ? COLOR_RED : COLOR_OFF;
            end
            default: begin
            end
        endcase

        plan.main_gnum  = green_num(r_in.main_level, r_gauge_full);
        plan.main_rnum  = red_num(r_in.main_level, r_gauge_full);
        plan.motor_gnum = green_num(r_in.motor_level, r_gauge_full);
        plan.motor_rnum = red_num(r_in.motor_level, r_gauge_full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gauge_full    <= 8'd255;
            r_radio_on      <= 8'd5;
            r_radio_period  <= 8'd130;
            r_charge_on     <= 8'd5;
            r_charge_period <= 8'd125;
            r_miss_on       <= 8'd15;
            r_miss_period   <= 8'd50;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GAUGE_FULL:    r_gauge_full    <= i_cfg_data;
                CFG_RADIO_ON:      r_radio_on      <= i_cfg_data;
                CFG_RADIO_PERIOD:  r_radio_period  <= i_cfg_data;
                CFG_CHARGE_ON:     r_charge_on     <= i_cfg_data;
                CFG_CHARGE_PERIOD: r_charge_period <= i_cfg_data;
                CFG_MISS_ON:       r_miss_on       <= i_cfg_data;
                CFG_MISS_PERIOD:   r_miss_period   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_prev_mode  <= MODE_NORMAL;
            r_shared_cnt <= 8'd0;
            r_charge_cnt <= 8'd0;
        end else begin
            if (i_tick.ready) begin
                r_in_valid <= i_tick.valid;
            end
            if (take) begin
                r_prev_mode  <= n_prev_mode;
                r_shared_cnt <= n_shared_cnt;
                r_charge_cnt <= n_charge_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick.valid && i_tick.ready) begin
            r_in <= i_tick.data;
        end
    end

endmodule

[sv/sled_emit.sv]
// Write sequencer: walks one tick plan and drives the command output register
module sled_emit #(
    parameter int LED_TOTAL = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_plan_valid,
    input  sled_pkg::t_plan i_plan,
    output logic            o_plan_ready,
    sled_stream_if.source   o_cmd
);
    import sled_pkg::*;

    localparam int IDX_W = $clog2(LED_TOTAL);

    // y / 5 for y < 1280
    function automatic logic [7:0] div5(input logic [10:0] y);
        logic [26:0] prod;
        prod = 27'(y) * 27'(16'd52429);
        return prod[25:18];
    endfunction

    function automatic t_phase first_phase(input t_plan p);
        if (p.bright_up) begin
            return PH_BRIGHT_UP;
        end else if (p.blank) begin
            return PH_BLANK;
        end else if (p.mode == MODE_NORMAL) begin
            return PH_NORM;
        end else if (p.mode == MODE_MISSING) begin
            return PH_MISS;
        end
        return PH_IDLE;
    endfunction

    t_phase           r_phase, n_phase;
    logic [IDX_W-1:0] r_idx, n_idx;
    t_plan            r_plan;
    logic             r_out_valid, n_out_valid;
    t_cmd             r_out, beat;
    logic             step, last, load;
    t_phase           cont_phase;
    logic [IDX_W-1:0] cont_idx;
    logic [14:0]      gnum;
    logic [13:0]      rnum;

    assign step         = (r_phase != PH_IDLE) && (!r_out_valid || o_cmd.ready);
    assign o_plan_ready = (r_phase == PH_IDLE) || (step && last);
    assign load         = i_plan_valid && o_plan_ready;
    assign o_cmd.valid  = r_out_valid;
    assign o_cmd.data   = r_out;

    always_comb begin
        beat       = '0;
        beat.color_code = COLOR_OFF;
        last       = 1'b0;
        cont_phase = r_phase;
        cont_idx   = r_idx + IDX_W'(1);
        gnum       = r_plan.main_gnum;
        rnum       = r_plan.main_rnum;

        unique case (r_phase)
            PH_IDLE: begin
                cont_idx = r_idx;
            end
            PH_BRIGHT_UP: begin
                beat.target     = 1'b1;
                beat.brightness = BRIGHT_NORMAL;
                cont_phase      = PH_BLANK;
                cont_idx        = '0;
            end
            PH_BLANK: begin
                beat.led_number = 4'(r_idx);
                if (r_idx == IDX_W'(LED_TOTAL - 1)) begin
                    cont_idx = '0;
                    unique case (r_plan.mode)
                        MODE_LOW:     cont_phase = PH_BRIGHT_LOW;
                        MODE_MISSING: cont_phase = PH_MISS;
                        default:      cont_phase = PH_NORM;
                    endcase
                end
            end
            PH_BRIGHT_LOW: begin
                beat.target     = 1'b1;
                beat.brightness = BRIGHT_LOW;
                cont_phase      = PH_LOW_RED;
            end
            PH_LOW_RED: begin
                beat.color_code = COLOR_RED;
                last            = 1'b1;
            end
            PH_NORM: begin
                beat.led_number = 4'(r_idx);
                last            = (r_idx == IDX_W'(3));
                unique case (r_idx[1:0])
                    2'd0: beat.color_code = r_plan.led0;
                    2'd1: begin
                        beat.color_code = r_plan.led1;
                        gnum            = r_plan.motor_gnum;
                        rnum            = r_plan.motor_rnum;
                    end
                    2'd2: beat.color_code = r_plan.led2;
                    default: beat.color_code = r_plan.led3;
                endcase
                if (beat.color_code == COLOR_GAUGE) begin
                    beat.green_level = div5(gnum[14:4]);
                    beat.red_level   = div5(rnum[13:3]);
                end
            end
            PH_MISS: begin
                beat.led_number = 4'd1;
                beat.color_code = r_plan.led1;
                last            = 1'b1;
            end
            default: begin
            end
        endcase
        beat.last_of_tick = last;

        n_phase     = r_phase;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !o_cmd.ready;
        if (step) begin
            n_out_valid = 1'b1;
            n_phase     = last ? PH_IDLE : cont_phase;
            n_idx       = cont_idx;
        end
        if (load) begin
            n_phase = first_phase(i_plan);
            n_idx   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_plan <= i_plan;
        end
        if (step) begin
            r_out <= beat;
        end
    end

endmodule

[sv/status_led_mode_sequencer.sv]
// Status LED mode sequencer top level
//
//  channel  | dir | payload         | beat
//  ---------+-----+-----------------+----------------------------------
//  i_tick   | in  | sled_pkg::t_tick | one update tick
//  o_cmd    | out | sled_pkg::t_cmd  | one LED color or brightness write
//  i_cfg_*  | in  | index, 8b data   | one register write
//
// A tick is held in an input register, decided combinationally and handed to the
// write sequencer, which sends 0 to LED_TOTAL+5 beats, one per cycle when o_cmd
// is ready. The next tick is accepted while the current one is still sending.
// A tick that starts in low battery and stays there sends nothing.
// Reset is synchronous: counters clear, mode returns to normal, registers take
// their defaults. Stalls on o_cmd hold the output register and back up the input.
module status_led_mode_sequencer #(
    parameter int LED_TOTAL   = 16,
    parameter int MOTOR_TOTAL = 6
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sled_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                     i_cfg_data,
    sled_stream_if.sink                    i_tick,
    sled_stream_if.source                  o_cmd
);
    import sled_pkg::*;

    logic  plan_valid;
    logic  plan_ready;
    t_plan plan;

    sled_plan #(
        .MOTOR_TOTAL (MOTOR_TOTAL)
    ) u_plan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_tick       (i_tick),
        .o_plan_valid (plan_valid),
        .o_plan       (plan),
        .i_plan_ready (plan_ready)
    );

    sled_emit #(
        .LED_TOTAL (LED_TOTAL)
    ) u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_plan_valid (plan_valid),
        .i_plan       (plan),
        .o_plan_ready (plan_ready),
        .o_cmd        (o_cmd)
    );

endmodule

[sv/sled_check.sv]
// Port-level checker for the status LED mode sequencer, with its bind
module sled_check (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input sled_pkg::t_cmd   i_out_data
);
    import sled_pkg::*;
    `include "status_led_mode_sequencer_assert.svh"

    logic out_wait;
    logic bright_beat;
    logic bright_shape;

    assign out_wait     = i_out_valid && !i_out_ready;
    assign bright_beat  = i_out_valid && i_out_data.target;
    assign bright_shape = i_out_data.led_number == 4'd0 && i_out_data.color_code == COLOR_OFF
                          && (i_out_data.brightness == BRIGHT_NORMAL
                              || i_out_data.brightness == BRIGHT_LOW)
                          && !i_out_data.last_of_tick;

    `SLED_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_wait, i_out_valid)
    `SLED_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, out_wait, $stable(i_out_data))
    `SLED_ASSERT_NEXT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n, !i_out_valid)
    `SLED_ASSERT_NOW(a_bright_form, i_clk, i_rst_n, bright_beat, bright_shape)

endmodule

bind status_led_mode_sequencer sled_check u_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_cmd.valid),
    .i_out_ready (o_cmd.ready),
    .i_out_data  (o_cmd.data)
);
